>>> hdl/sat_pkg.sv
// Shared types, constants and command codes for the slot alarm table.
package sat_pkg;

  // Table geometry.
  localparam int SLOTS       = 8;
  localparam int TIMES       = 8;
  localparam int DAY_MINUTES = 24 * 60;

  // Fixed field widths of the item and result formats.
  localparam int CMD_W    = 3;
  localparam int SLOT_W   = 3;
  localparam int AMOUNT_W = 16;
  localparam int MINUTE_W = 11;
  localparam int COUNT_W  = 4;

  // Widths that follow from the table geometry.
  localparam int SLOT_IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TIME_IDX_W  = (TIMES > 1) ? $clog2(TIMES) : 1;
  localparam int MEM_ADDR_W  = SLOT_IDX_W + TIME_IDX_W;
  localparam int ALARM_CNT_W = $clog2(TIMES + 1);
  localparam int MATCH_CNT_W = $clog2(SLOTS + 1);
  localparam int SLOT_TOT_W  = $clog2(SLOTS + 1);

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_SET      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_COUNT    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ADD      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DISPENSE = 3'd4;
  localparam logic [CMD_W-1:0] CMD_QUERY    = 3'd5;

  typedef logic [SLOT_IDX_W-1:0]  slot_idx_t;
  typedef logic [MEM_ADDR_W-1:0]  mem_addr_t;
  typedef logic [ALARM_CNT_W-1:0] alarm_cnt_t;
  typedef logic [MATCH_CNT_W-1:0] match_cnt_t;
  typedef logic [SLOT_TOT_W-1:0]  slot_tot_t;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [SLOT_W-1:0]   slot;
    logic [AMOUNT_W-1:0] amount;
    logic [MINUTE_W-1:0] alarm_time;
    logic [MINUTE_W-1:0] current_time;
  } item_t;

  typedef struct packed {
    logic                ok;
    logic [AMOUNT_W-1:0] amount_left;
    logic [COUNT_W-1:0]  slot_count;
    logic [MINUTE_W-1:0] next_time;
    logic [COUNT_W-1:0]  match_count;
    logic [SLOT_W-1:0]   match_slot;
    logic                last;
  } result_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic exec;
    logic scan;
    logic emit;
  } ctrl_t;

  // Datapath to controller status.
  typedef struct packed {
    logic is_query;
    logic scan_last;
    logic emit_last;
  } stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

endpackage

>>> hdl/sat_ctrl.sv
// Sequencing state machine of the slot alarm table.
module sat_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  sat_pkg::stat_t stat,
  output sat_pkg::ctrl_t ctrl,
  output logic           busy
);

  sat_pkg::state_t state;
  sat_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sat_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sat_pkg::ST_IDLE: begin
        if (start) begin
          state_next = stat.is_query ? sat_pkg::ST_SCAN : sat_pkg::ST_EXEC;
        end
      end
      sat_pkg::ST_EXEC: begin
        state_next = sat_pkg::ST_IDLE;
      end
      sat_pkg::ST_SCAN: begin
        if (stat.scan_last) begin
          state_next = sat_pkg::ST_DRAIN;
        end
      end
      sat_pkg::ST_DRAIN: begin
        state_next = sat_pkg::ST_EMIT;
      end
      sat_pkg::ST_EMIT: begin
        if (stat.emit_last) begin
          state_next = sat_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sat_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl = '0;
    busy = 1'b1;
    unique case (state)
      sat_pkg::ST_IDLE: begin
        busy      = 1'b0;
        ctrl.load = start;
      end
      sat_pkg::ST_EXEC: begin
        ctrl.exec = 1'b1;
      end
      sat_pkg::ST_SCAN: begin
        ctrl.scan = 1'b1;
      end
      sat_pkg::ST_DRAIN: begin
        ctrl = '0;
      end
      sat_pkg::ST_EMIT: begin
        ctrl.emit = 1'b1;
      end
      default: begin
        ctrl = '0;
      end
    endcase
  end

endmodule

>>> hdl/sat_dp.sv
// Datapath of the slot alarm table: slot registers, alarm memory, scan and result register.
module sat_dp (
  input  logic             clk,
  input  logic             rst,
  input  sat_pkg::item_t   item,
  input  sat_pkg::ctrl_t   ctrl,
  output sat_pkg::stat_t   stat,
  output logic             done,
  output sat_pkg::result_t result
);

  // Latched item.
  sat_pkg::item_t item_q;

  // Per-slot state.
  logic                          slot_enabled [sat_pkg::SLOTS];
  logic [sat_pkg::AMOUNT_W-1:0]  slot_amount  [sat_pkg::SLOTS];
  sat_pkg::alarm_cnt_t           alarm_count  [sat_pkg::SLOTS];
  sat_pkg::slot_tot_t            enabled_total;

  // Alarm minutes, one row of TIMES entries per slot.
  logic [sat_pkg::MINUTE_W-1:0]  alarm_mem [sat_pkg::SLOTS * sat_pkg::TIMES];
  logic [sat_pkg::MINUTE_W-1:0]  rd_data;

  // Scan state.
  sat_pkg::mem_addr_t            scan_idx;
  logic                          rd_valid;
  sat_pkg::slot_idx_t            rd_slot;
  logic [sat_pkg::MINUTE_W-1:0]  best;
  sat_pkg::match_cnt_t           match_n;
  sat_pkg::slot_idx_t            match_list [sat_pkg::SLOTS];
  sat_pkg::slot_idx_t            emit_k;

  // Slot selection and lookups.
  sat_pkg::slot_idx_t            sel_idx;
  logic                          sel_en;
  logic [sat_pkg::AMOUNT_W-1:0]  sel_amt;
  sat_pkg::alarm_cnt_t           sel_cnt;
  logic [sat_pkg::TIME_IDX_W-1:0] scan_j;

  // Command evaluation.
  logic                          in_range;
  logic                          known;
  logic                          ok;
  logic                          en_next;
  logic [sat_pkg::AMOUNT_W-1:0]  amt_next;
  logic                          cnt_inc;
  sat_pkg::slot_tot_t            total_next;
  sat_pkg::mem_addr_t            wr_addr;
  logic                          hit;
  sat_pkg::result_t              result_next;

  assign scan_j  = scan_idx[sat_pkg::TIME_IDX_W-1:0];
  assign sel_idx = ctrl.scan ? scan_idx[sat_pkg::MEM_ADDR_W-1 -: sat_pkg::SLOT_IDX_W]
                             : item_q.slot[sat_pkg::SLOT_IDX_W-1:0];
  assign sel_en  = slot_enabled[sel_idx];
  assign sel_amt = slot_amount[sel_idx];
  assign sel_cnt = alarm_count[sel_idx];
  assign wr_addr = {sel_idx, sel_cnt[sat_pkg::TIME_IDX_W-1:0]};

  assign in_range = int'(item_q.slot) < sat_pkg::SLOTS;

  always_comb begin
    known      = 1'b0;
    ok         = 1'b0;
    en_next    = sel_en;
    amt_next   = sel_amt;
    cnt_inc    = 1'b0;
    total_next = enabled_total;
    if (in_range) begin
      unique case (item_q.cmd)
        sat_pkg::CMD_SET: begin
          known    = 1'b1;
          ok       = 1'b1;
          amt_next = item_q.amount;
          if (!sel_en) begin
            en_next    = 1'b1;
            total_next = enabled_total + 1'b1;
          end
        end
        sat_pkg::CMD_COUNT: begin
          known    = 1'b1;
          ok       = 1'b1;
          amt_next = item_q.amount;
        end
        sat_pkg::CMD_REMOVE: begin
          known = 1'b1;
          ok    = 1'b1;
          if (sel_en) begin
            en_next    = 1'b0;
            total_next = enabled_total - 1'b1;
          end
        end
        sat_pkg::CMD_ADD: begin
          known = 1'b1;
          if (sel_en && (sel_cnt < sat_pkg::ALARM_CNT_W'(sat_pkg::TIMES))) begin
            ok      = 1'b1;
            cnt_inc = 1'b1;
          end
        end
        sat_pkg::CMD_DISPENSE: begin
          known = 1'b1;
          if (sel_en && (sel_amt != '0)) begin
            ok       = 1'b1;
            amt_next = sel_amt - 1'b1;
          end
        end
        default: begin
          known = 1'b0;
        end
      endcase
    end
  end

  // Item latch.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      item_q <= item;
    end
  end

  // Slot table update.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < sat_pkg::SLOTS; i++) begin
        slot_enabled[i] <= 1'b0;
        slot_amount[i]  <= '0;
        alarm_count[i]  <= '0;
      end
      enabled_total <= '0;
    end else if (ctrl.exec) begin
      slot_enabled[sel_idx] <= en_next;
      slot_amount[sel_idx]  <= amt_next;
      enabled_total         <= total_next;
      if (cnt_inc) begin
        alarm_count[sel_idx] <= sel_cnt + 1'b1;
      end
    end
  end

  // Alarm memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (ctrl.exec && cnt_inc) begin
      alarm_mem[wr_addr] <= item_q.alarm_time;
    end
    rd_data <= alarm_mem[scan_idx];
  end

  // Scan address and the valid flag that travels with the read.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (ctrl.load) begin
        scan_idx <= '0;
      end else if (ctrl.scan) begin
        scan_idx <= scan_idx + 1'b1;
      end
      rd_valid <= ctrl.scan && sel_en && (sat_pkg::ALARM_CNT_W'(scan_j) < sel_cnt);
    end
  end

  always_ff @(posedge clk) begin
    rd_slot <= sel_idx;
  end

  // Running minimum and tie list.
  assign hit = rd_valid && (rd_data > item_q.current_time)
            && (rd_data < sat_pkg::MINUTE_W'(sat_pkg::DAY_MINUTES));

  always_ff @(posedge clk) begin
    if (rst) begin
      best    <= sat_pkg::MINUTE_W'(sat_pkg::DAY_MINUTES);
      match_n <= '0;
    end else if (ctrl.load) begin
      best    <= sat_pkg::MINUTE_W'(sat_pkg::DAY_MINUTES);
      match_n <= '0;
    end else if (hit) begin
      if (rd_data < best) begin
        best          <= rd_data;
        match_list[0] <= rd_slot;
        match_n       <= sat_pkg::MATCH_CNT_W'(1);
      end else if ((rd_data == best) && (match_n < sat_pkg::MATCH_CNT_W'(sat_pkg::SLOTS))) begin
        match_list[match_n[sat_pkg::SLOT_IDX_W-1:0]] <= rd_slot;
        match_n <= match_n + 1'b1;
      end
    end
  end

  // Result index during the output phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      emit_k <= '0;
    end else if (ctrl.load) begin
      emit_k <= '0;
    end else if (ctrl.emit) begin
      emit_k <= emit_k + 1'b1;
    end
  end

  assign stat.is_query  = item.cmd == sat_pkg::CMD_QUERY;
  assign stat.scan_last = scan_idx == '1;
  assign stat.emit_last = (match_n == '0)
                       || ((sat_pkg::MATCH_CNT_W'(emit_k) + 1'b1) == match_n);

  always_comb begin
    result_next = '0;
    if (ctrl.emit) begin
      result_next.ok          = 1'b1;
      result_next.slot_count  = sat_pkg::COUNT_W'(enabled_total);
      result_next.next_time   = best;
      result_next.match_count = sat_pkg::COUNT_W'(match_n);
      result_next.match_slot  = (match_n == '0) ? '0 : sat_pkg::SLOT_W'(match_list[emit_k]);
      result_next.last        = stat.emit_last;
    end else begin
      result_next.ok          = ok;
      result_next.amount_left = known ? amt_next : '0;
      result_next.slot_count  = sat_pkg::COUNT_W'(total_next);
      result_next.last        = 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.exec || ctrl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec || ctrl.emit) begin
      result <= result_next;
    end
  end

endmodule

>>> hdl/slot_alarm_table_top.sv
// Top level of the slot alarm table: controller and datapath.
//
// An item is taken at a rising edge with start high and busy low. Every item
// produces one or more results, each shown on the result port for exactly one
// cycle while done is high; the receiver must take it then, since the block
// cannot be held off. Slot commands (set, set count, remove, add alarm,
// dispense) and unknown codes give one result, registered in the output
// register from the EXEC state, and busy is high for one cycle, so a new such
// command can be issued as soon as busy falls again. A next-alarm query walks
// the alarm memory one entry per cycle over all SLOTS * TIMES entries (64),
// passes a drain state for the last read, and then emits one result per
// matching slot entry on consecutive cycles, at least one and at most SLOTS.
// The scan length is fixed by the single read port of the alarm memory. The
// final result of every item has last set. Only minutes stored by add alarm
// are ever read, so the alarm memory needs no clearing after reset.
module slot_alarm_table_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  sat_pkg::item_t   item,
  output logic             done,
  output sat_pkg::result_t result
);

  sat_pkg::ctrl_t ctrl;
  sat_pkg::stat_t stat;

  sat_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  sat_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .ctrl   (ctrl),
    .stat   (stat),
    .done   (done),
    .result (result)
  );

endmodule

>>> hdl/sat_checker.sv
// Port-level assertions for the slot alarm table and their binding.
module sat_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input sat_pkg::result_t result
);

  // An accepted item keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after an accepted item");

  // The final result of an item is followed by an idle output cycle.
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    done && result.last |=> !done)
    else $error("result right after a final result");

  // Query results come on consecutive cycles until the last one.
  a_burst: assert property (@(posedge clk) disable iff (rst)
    done && !result.last |=> done)
    else $error("gap inside a result burst");

  // All results of one query carry the same minute.
  a_burst_time: assert property (@(posedge clk) disable iff (rst)
    done && !result.last |=> result.next_time == $past(result.next_time))
    else $error("next_time changed inside a result burst");

  // A result without matches is always the only one.
  a_no_match_last: assert property (@(posedge clk) disable iff (rst)
    done && (result.match_count == '0) |-> result.last)
    else $error("result without matches is not final");

endmodule

bind slot_alarm_table_top sat_checker u_sat_checker (.*);
